>>> design/nfs_pkg.sv
// Shared types, widths and codes for the nearest free slot allocator.
// Used by the channel interfaces, the slot RAM, the distance unit and the top level.
`default_nettype none

package nfs_pkg;

   localparam int MAX_COLS_DEF = 16;
   localparam int MAX_ROWS_DEF = 8;

   // Field widths of the channels and the register port
   localparam int KIND_W     = 1;
   localparam int SX_W       = 5;
   localparam int SY_W       = 4;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int COUNT_W    = 8;
   localparam int CMP_W      = 8;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

   localparam logic [4:0] GRID_COLUMNS_RST = 5'd16;
   localparam logic [3:0] GRID_ROWS_RST    = 4'd8;
   localparam logic [4:0] REF_X_RST        = 5'd1;
   localparam logic [3:0] REF_Y_RST        = 4'd1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ALLOCATED      = 3'd0,
      STAT_FULL           = 3'd1,
      STAT_RELEASED       = 3'd2,
      STAT_ALREADY_FREE   = 3'd3,
      STAT_NONE_ALLOCATED = 3'd4,
      STAT_OFF_GRID       = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLUMNS = 2'd0,
      CSR_GRID_ROWS    = 2'd1,
      CSR_REF_X        = 2'd2,
      CSR_REF_Y        = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SCAN_LAST,
      S_ALLOC,
      S_REL_RD,
      S_REL_CHK,
      S_DONE
   } state_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

>>> design/nfs_req_if.sv
// Request channel: valid/ready handshake carrying one allocate or release word.
// Depends on nfs_pkg for field widths.
`default_nettype none

interface nfs_req_if;
   logic                        valid;
   logic                        ready;
   logic [nfs_pkg::KIND_W-1:0] kind;
   logic [nfs_pkg::SX_W-1:0]   slot_x;
   logic [nfs_pkg::SY_W-1:0]   slot_y;

   modport source (output valid, output kind, output slot_x, output slot_y, input ready);
   modport sink   (input valid, input kind, input slot_x, input slot_y, output ready);
endinterface

`default_nettype wire

>>> design/nfs_rsp_if.sv
// Response channel: valid/ready handshake carrying one status word per request.
// Depends on nfs_pkg for field widths.
`default_nettype none

interface nfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nfs_pkg::STATUS_W-1:0] status;
   logic [nfs_pkg::SX_W-1:0]     got_x;
   logic [nfs_pkg::SY_W-1:0]     got_y;

   modport source (output valid, output status, output got_x, output got_y, input ready);
   modport sink   (input valid, input status, input got_x, input got_y, output ready);
endinterface

`default_nettype wire

>>> design/nearest_free_slot_allocator.sv
// Nearest free slot allocator: top level with sequencer, slot map and register file.
// Depends on nfs_pkg, nfs_req_if, nfs_rsp_if, nfs_ram and nfs_dist.
`default_nettype none

// An allocate word walks every slot of the active grid in row-major order, one slot per
// cycle: the slot map RAM is read and the shared distance unit scores the same slot, and
// the running minimum keeps the first slot with the smallest squared distance. One word
// is in flight at a time and req ready is low meanwhile; a finished response waits in
// the output register and does not stall the next request until its result is ready.
// After reset a clearing pass writes every entry of the slot map with req ready low;
// register writes are taken throughout.
module nearest_free_slot_allocator #(
   parameter int MAX_COLS = nfs_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = nfs_pkg::MAX_ROWS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   nfs_req_if.sink                             req_chan,
   nfs_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [nfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [nfs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_TOTAL = MAX_COLS * MAX_ROWS;
   localparam int AW  = nfs_pkg::addr_width(SLOT_TOTAL);
   localparam int XW  = $clog2(MAX_COLS + 1);
   localparam int YW  = $clog2(MAX_ROWS + 1);
   localparam int DXW = (XW > nfs_pkg::SX_W) ? XW : nfs_pkg::SX_W;
   localparam int DYW = (YW > nfs_pkg::SY_W) ? YW : nfs_pkg::SY_W;
   localparam int DW  = 2 * ((DXW > DYW) ? DXW : DYW) + 1;
   localparam int CW  = nfs_pkg::CMP_W;
   localparam int NW  = nfs_pkg::COUNT_W;

   nfs_pkg::state_type state_ff, state_in;

   // Register file
   logic [nfs_pkg::SX_W-1:0] cols_cfg_ff;
   logic [nfs_pkg::SY_W-1:0] rows_cfg_ff;
   logic [nfs_pkg::SX_W-1:0] ref_x_ff;
   logic [nfs_pkg::SY_W-1:0] ref_y_ff;

   // Latched request
   logic [nfs_pkg::SX_W-1:0] sx_ff;
   logic [nfs_pkg::SY_W-1:0] sy_ff;

   // Scan counters and pipeline stage aligned with RAM read and distance unit
   logic [XW-1:0] x_ff, px_ff;
   logic [YW-1:0] y_ff, py_ff;
   logic          p_ff;

   // Running minimum
   logic          found_ff;
   logic [DW-1:0] best_d_ff;
   logic [XW-1:0] bx_ff;
   logic [YW-1:0] by_ff;

   logic [NW-1:0] count_ff;
   logic [AW-1:0] clr_addr_ff;

   // Result of the current word and the output register
   nfs_pkg::status_type      res_status_ff;
   logic [nfs_pkg::SX_W-1:0] res_x_ff;
   logic [nfs_pkg::SY_W-1:0] res_y_ff;
   logic                     rsp_valid_ff;
   nfs_pkg::status_type      rsp_status_ff;
   logic [nfs_pkg::SX_W-1:0] rsp_x_ff;
   logic [nfs_pkg::SY_W-1:0] rsp_y_ff;

   logic [XW-1:0] cols_act;
   logic [YW-1:0] rows_act;
   logic          off_grid;
   logic          req_fire;
   logic          issue;
   logic          rsp_load;
   logic          better;
   logic [AW-1:0] scan_addr, rel_addr, best_addr;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic          ram_wdata;
   logic          ram_rdata;
   logic [DW-1:0] sq_dist;

   // Clamp the configured grid to 1..MAX
   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols_act = XW'(1);
      end else if (CW'(cols_cfg_ff) > CW'(MAX_COLS)) begin
         cols_act = XW'(MAX_COLS);
      end else begin
         cols_act = XW'(cols_cfg_ff);
      end
      if (rows_cfg_ff == '0) begin
         rows_act = YW'(1);
      end else if (CW'(rows_cfg_ff) > CW'(MAX_ROWS)) begin
         rows_act = YW'(MAX_ROWS);
      end else begin
         rows_act = YW'(rows_cfg_ff);
      end
   end

   assign off_grid = (sx_ff == '0) || (CW'(sx_ff) > CW'(cols_act)) ||
                     (sy_ff == '0) || (CW'(sy_ff) > CW'(rows_act));

   assign scan_addr = AW'((int'(y_ff) - 1) * MAX_COLS + int'(x_ff) - 1);
   assign rel_addr  = AW'((int'(sy_ff) - 1) * MAX_COLS + int'(sx_ff) - 1);
   assign best_addr = AW'((int'(by_ff) - 1) * MAX_COLS + int'(bx_ff) - 1);

   assign req_chan.ready = (state_ff == nfs_pkg::S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign better         = p_ff && !ram_rdata && (!found_ff || (sq_dist < best_d_ff));

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      issue     = 1'b0;
      rsp_load  = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = clr_addr_ff;
      ram_wdata = 1'b0;
      ram_raddr = scan_addr;
      unique case (state_ff)
         nfs_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            if (clr_addr_ff == AW'(SLOT_TOTAL - 1)) begin
               state_in = nfs_pkg::S_IDLE;
            end
         end
         nfs_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.kind == nfs_pkg::KIND_RELEASE) ?
                          nfs_pkg::S_REL_RD : nfs_pkg::S_SCAN;
            end
         end
         nfs_pkg::S_SCAN: begin
            issue = 1'b1;
            if ((x_ff == cols_act) && (y_ff == rows_act)) begin
               state_in = nfs_pkg::S_SCAN_LAST;
            end
         end
         nfs_pkg::S_SCAN_LAST: begin
            // last slot leaves the pipeline this cycle
            state_in = nfs_pkg::S_ALLOC;
         end
         nfs_pkg::S_ALLOC: begin
            if (found_ff) begin
               ram_we    = 1'b1;
               ram_waddr = best_addr;
               ram_wdata = 1'b1;
            end
            state_in = nfs_pkg::S_DONE;
         end
         nfs_pkg::S_REL_RD: begin
            ram_raddr = rel_addr;
            if ((count_ff == '0) || off_grid) begin
               state_in = nfs_pkg::S_DONE;
            end else begin
               state_in = nfs_pkg::S_REL_CHK;
            end
         end
         nfs_pkg::S_REL_CHK: begin
            if (ram_rdata) begin
               ram_we    = 1'b1;
               ram_waddr = rel_addr;
               ram_wdata = 1'b0;
            end
            state_in = nfs_pkg::S_DONE;
         end
         nfs_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = nfs_pkg::S_IDLE;
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfs_pkg::S_CLEAR;
         clr_addr_ff  <= '0;
         p_ff         <= 1'b0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cols_cfg_ff  <= nfs_pkg::GRID_COLUMNS_RST;
         rows_cfg_ff  <= nfs_pkg::GRID_ROWS_RST;
         ref_x_ff     <= nfs_pkg::REF_X_RST;
         ref_y_ff     <= nfs_pkg::REF_Y_RST;
      end else begin
         state_ff <= state_in;
         p_ff     <= issue;
         if (state_ff == nfs_pkg::S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (req_fire) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
         if ((state_ff == nfs_pkg::S_ALLOC) && found_ff) begin
            count_ff <= count_ff + NW'(1);
         end else if ((state_ff == nfs_pkg::S_REL_CHK) && ram_rdata) begin
            count_ff <= count_ff - NW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (nfs_pkg::csr_index_type'(csr_index))
               nfs_pkg::CSR_GRID_COLUMNS: cols_cfg_ff <= csr_wdata[nfs_pkg::SX_W-1:0];
               nfs_pkg::CSR_GRID_ROWS:    rows_cfg_ff <= csr_wdata[nfs_pkg::SY_W-1:0];
               nfs_pkg::CSR_REF_X:        ref_x_ff    <= csr_wdata[nfs_pkg::SX_W-1:0];
               nfs_pkg::CSR_REF_Y:        ref_y_ff    <= csr_wdata[nfs_pkg::SY_W-1:0];
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sx_ff <= req_chan.slot_x;
         sy_ff <= req_chan.slot_y;
         x_ff  <= XW'(1);
         y_ff  <= YW'(1);
      end else if (issue) begin
         if (x_ff == cols_act) begin
            x_ff <= XW'(1);
            y_ff <= y_ff + YW'(1);
         end else begin
            x_ff <= x_ff + XW'(1);
         end
      end
      px_ff <= x_ff;
      py_ff <= y_ff;
      if (better) begin
         best_d_ff <= sq_dist;
         bx_ff     <= px_ff;
         by_ff     <= py_ff;
      end
      unique case (state_ff)
         nfs_pkg::S_ALLOC: begin
            res_status_ff <= found_ff ? nfs_pkg::STAT_ALLOCATED : nfs_pkg::STAT_FULL;
            res_x_ff      <= found_ff ? nfs_pkg::SX_W'(bx_ff) : '0;
            res_y_ff      <= found_ff ? nfs_pkg::SY_W'(by_ff) : '0;
         end
         nfs_pkg::S_REL_RD: begin
            res_status_ff <= (count_ff == '0) ? nfs_pkg::STAT_NONE_ALLOCATED :
                                                nfs_pkg::STAT_OFF_GRID;
            res_x_ff      <= '0;
            res_y_ff      <= '0;
         end
         nfs_pkg::S_REL_CHK: begin
            res_status_ff <= ram_rdata ? nfs_pkg::STAT_RELEASED :
                                         nfs_pkg::STAT_ALREADY_FREE;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_x_ff      <= res_x_ff;
         rsp_y_ff      <= res_y_ff;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.got_x  = rsp_x_ff;
   assign rsp_chan.got_y  = rsp_y_ff;

   nfs_ram #(
      .WIDTH (1),
      .DEPTH (SLOT_TOTAL)
   ) u_slot_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   nfs_dist #(
      .XW (XW),
      .YW (YW),
      .DW (DW)
   ) u_dist (
      .clock    (clock),
      .x        (x_ff),
      .y        (y_ff),
      .ref_x    (ref_x_ff),
      .ref_y    (ref_y_ff),
      .dist_out (sq_dist)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a word is in progress");

   a_alloc_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == nfs_pkg::STAT_ALLOCATED)) |->
      ((rsp_chan.got_x != '0) && (rsp_chan.got_y != '0)))
      else $error("allocated slot has zero coordinate");

   a_other_coords_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != nfs_pkg::STAT_ALLOCATED)) |->
      ((rsp_chan.got_x == '0) && (rsp_chan.got_y == '0)))
      else $error("coordinates set on a non-allocate status");

   a_count_on_alloc: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == nfs_pkg::S_ALLOC) && found_ff) |=>
      (count_ff == NW'($past(count_ff) + NW'(1))))
      else $error("used count not advanced on allocation");
`endif

endmodule

`default_nettype wire

>>> design/nfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nfs_pkg for the address width function.
`default_nettype none

module nfs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [nfs_pkg::addr_width(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [nfs_pkg::addr_width(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/nfs_dist.sv
// Shared distance unit: squared Euclidean distance of one slot to the reference point.
// One result per cycle, registered. Depends on nfs_pkg for the reference widths.
`default_nettype none

module nfs_dist #(
   parameter int XW = 5,
   parameter int YW = 4,
   parameter int DW = 11
) (
   input  wire logic                     clock,
   input  wire logic [XW-1:0]            x,
   input  wire logic [YW-1:0]            y,
   input  wire logic [nfs_pkg::SX_W-1:0] ref_x,
   input  wire logic [nfs_pkg::SY_W-1:0] ref_y,
   output      logic [DW-1:0]            dist_out
);

   localparam int DXW = (XW > nfs_pkg::SX_W) ? XW : nfs_pkg::SX_W;
   localparam int DYW = (YW > nfs_pkg::SY_W) ? YW : nfs_pkg::SY_W;

   logic [DXW-1:0] xe, rxe, dx;
   logic [DYW-1:0] ye, rye, dy;
   logic [DW-1:0]  dist_in;
   logic [DW-1:0]  dist_ff;

   always_comb begin
      xe      = DXW'(x);
      rxe     = DXW'(ref_x);
      ye      = DYW'(y);
      rye     = DYW'(ref_y);
      dx      = (xe > rxe) ? (xe - rxe) : (rxe - xe);
      dy      = (ye > rye) ? (ye - rye) : (rye - ye);
      dist_in = DW'(dx) * DW'(dx) + DW'(dy) * DW'(dy);
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign dist_out = dist_ff;

endmodule

`default_nettype wire
